### rtl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants of the nearest-neighbor frame scaler: pixel
// layout, operation codes and configuration register map.
// ----------------------------------------------------------------------------
package nns_pkg;

    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_RESET = 256;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    // operation carried by an input beat
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    // one stored pixel, red in the top byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

endpackage

### rtl/nns_div.sv
// ----------------------------------------------------------------------------
// nns_div
// Coordinate mapper: computes min(floor((2*pos*src + dst) / (2*dst)), src-1)
// with a shift-subtract divider, one quotient bit per cycle. Setup and a
// clamp compare come before the quotient steps, and done follows the last.
// ----------------------------------------------------------------------------
module nns_div #(
    parameter  int MAX_SIZE = 256,
    parameter  int STEPS    = 8,
    localparam int QW       = $clog2(MAX_SIZE),
    localparam int SW       = $clog2(MAX_SIZE + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [QW-1:0] pos,
    input  logic [SW-1:0] src_size,
    input  logic [SW-1:0] dst_size,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int NW    = SW + STEPS + 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_STEP
    } state_t;

    state_t             state_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NW-1:0]      num_reg;
    logic [NW-1:0]      lim_reg;
    logic [NW-1:0]      den_sh_reg;
    logic [QW-1:0]      smax_reg;
    logic               clamp_reg;
    logic [STEPS-1:0]   q_reg;
    logic               fits;

    // sequencer: setup, clamp compare, then one step per quotient bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (state_reg == ST_STEP) && (cnt_reg == '0);
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_STEP;
                    cnt_reg   <= CNT_W'(STEPS - 1);
                end
                ST_STEP: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign fits = (num_reg >= den_sh_reg);

    // datapath: numerator, clamp limit and shifted divisor
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            num_reg    <= ((NW'(pos) * NW'(src_size)) << 1) + NW'(dst_size);
            lim_reg    <= (NW'(dst_size) * NW'(src_size)) << 1;
            den_sh_reg <= NW'(dst_size) << STEPS;
            smax_reg   <= QW'(src_size - 1'b1);
        end
        if (state_reg == ST_CMP) begin
            clamp_reg <= (num_reg >= lim_reg);
            q_reg     <= '0;
        end
        if (state_reg == ST_STEP) begin
            if (fits) begin
                num_reg <= num_reg - den_sh_reg;
            end
            q_reg      <= STEPS'({q_reg, fits});
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = clamp_reg ? smax_reg : QW'(q_reg);

    // a new request only arrives while the unit is free
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ST_IDLE)
        else $error("nns_div: start while busy");

    // done follows the last quotient step
    a_done_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg == ST_STEP))
        else $error("nns_div: done without a final step");

    // remainder stays below twice the current divisor when not clamped
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && !clamp_reg) |-> ({1'b0, num_reg} < {den_sh_reg, 1'b0}))
        else $error("nns_div: partial remainder out of range");

endmodule

### rtl/nns_fstore.sv
// ----------------------------------------------------------------------------
// nns_fstore
// Frame store: one write port and one read port, read data registered and
// held until the next read.
// ----------------------------------------------------------------------------
module nns_fstore
    import nns_pkg::*;
#(
    parameter  int DEPTH = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pixel_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output pixel_t        rd_data
);

    pixel_t store_mem [0:DEPTH-1];
    pixel_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nearest_neighbor_image_scaler_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Nearest-neighbor RGB frame scaler with a frame store and coordinate mappers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each beat is a load (s_operation = 0), which writes
//   the next source pixel in raster order, or an emit (s_operation = 1),
//   which requests the next destination pixel in raster order.
//   Output channel (m_*): one beat per emit with the chosen source pixel;
//   m_frame_end marks the last pixel of the destination frame.
//   Config channel (cfg_*): always ready; writes sizes, 0 acts as 1 and values
//   above the maximum saturate. Write only while the block is idle.
//   Loads are taken one per cycle while the block is idle and may arrive
//   back to back. An emit runs both coordinate dividers in parallel, one
//   quotient bit per cycle, for max(clog2(MAX_WIDTH), clog2(MAX_HEIGHT))
//   steps plus setup, then one frame store read; the result then waits for
//   the output register to be free, and s_ready goes high again as the
//   result shows up there. s_ready is low from the emit beat until then.
//   A finished result sits in the output register; loads keep being taken
//   while the receiver stalls, and a following emit waits at its end.
//   Reset clears positions and sets all sizes to 256 (or the maximum); the
//   frame store content is undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_top
    import nns_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [CH_W-1:0]       s_in_red,
    input  logic [CH_W-1:0]       s_in_green,
    input  logic [CH_W-1:0]       s_in_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_out_red,
    output logic [CH_W-1:0]       m_out_green,
    output logic [CH_W-1:0]       m_out_blue,
    output logic                  m_frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PWX   = $clog2(MAX_WIDTH);
    localparam int PWY   = $clog2(MAX_HEIGHT);
    localparam int SWX   = $clog2(MAX_WIDTH + 1);
    localparam int SWY   = $clog2(MAX_HEIGHT + 1);
    localparam int STEPS = (PWX > PWY) ? PWX : PWY;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CWX   = (SWX > CFG_DATA_W) ? SWX : CFG_DATA_W;
    localparam int CWY   = (SWY > CFG_DATA_W) ? SWY : CFG_DATA_W;
    localparam int RST_W = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
    localparam int RST_H = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DATA
    } state_t;

    state_t           state_reg;
    logic             m_valid_reg;
    pixel_t           m_pix_reg;
    logic             m_last_reg;
    logic             last_reg;

    logic [SWX-1:0]   src_w_reg;
    logic [SWY-1:0]   src_h_reg;
    logic [SWX-1:0]   dst_w_reg;
    logic [SWY-1:0]   dst_h_reg;

    logic [PWX-1:0]   load_col_reg, load_col_next;
    logic [PWY-1:0]   load_row_reg, load_row_next;
    logic [PWX-1:0]   emit_col_reg, emit_col_next;
    logic [PWY-1:0]   emit_row_reg, emit_row_next;

    logic             in_beat;
    logic             load_beat;
    logic             emit_beat;
    logic             cfg_beat;
    logic             out_free;
    logic             emit_last;

    logic [CWX-1:0]   cfg_ext_x;
    logic [CWY-1:0]   cfg_ext_y;
    logic [SWX-1:0]   cfg_sat_w;
    logic [SWY-1:0]   cfg_sat_h;

    logic             div_x_done;
    logic             div_y_done;
    logic [PWX-1:0]   src_x;
    logic [PWY-1:0]   src_y;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    pixel_t           wr_pixel;
    pixel_t           rd_pixel;

    // handshakes
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign load_beat = in_beat && (op_t'(s_operation) == OP_LOAD);
    assign emit_beat = in_beat && (op_t'(s_operation) == OP_EMIT);
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // size saturation for config writes
    always_comb begin
        cfg_ext_x = CWX'(cfg_data);
        cfg_ext_y = CWY'(cfg_data);
        if (cfg_data == '0) begin
            cfg_sat_w = SWX'(1);
        end else if (cfg_ext_x > CWX'(MAX_WIDTH)) begin
            cfg_sat_w = SWX'(MAX_WIDTH);
        end else begin
            cfg_sat_w = SWX'(cfg_data);
        end
        if (cfg_data == '0) begin
            cfg_sat_h = SWY'(1);
        end else if (cfg_ext_y > CWY'(MAX_HEIGHT)) begin
            cfg_sat_h = SWY'(MAX_HEIGHT);
        end else begin
            cfg_sat_h = SWY'(cfg_data);
        end
    end

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SWX'(RST_W);
            src_h_reg <= SWY'(RST_H);
            dst_w_reg <= SWX'(RST_W);
            dst_h_reg <= SWY'(RST_H);
        end else if (cfg_beat) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_sat_w;
                REG_SRC_HEIGHT: src_h_reg <= cfg_sat_h;
                REG_DST_WIDTH:  dst_w_reg <= cfg_sat_w;
                REG_DST_HEIGHT: dst_h_reg <= cfg_sat_h;
            endcase
        end
    end

    // raster position advance for load and emit
    always_comb begin
        load_col_next = load_col_reg;
        load_row_next = load_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        if (load_beat) begin
            if (SWX'(load_col_reg) + SWX'(1) >= src_w_reg) begin
                load_col_next = '0;
                if (SWY'(load_row_reg) + SWY'(1) >= src_h_reg) begin
                    load_row_next = '0;
                end else begin
                    load_row_next = load_row_reg + 1'b1;
                end
            end else begin
                load_col_next = load_col_reg + 1'b1;
            end
        end
        if (emit_beat) begin
            if (SWX'(emit_col_reg) + SWX'(1) >= dst_w_reg) begin
                emit_col_next = '0;
                if (SWY'(emit_row_reg) + SWY'(1) >= dst_h_reg) begin
                    emit_row_next = '0;
                end else begin
                    emit_row_next = emit_row_reg + 1'b1;
                end
            end else begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end
    end

    assign emit_last = (SWX'(emit_col_reg) + SWX'(1) >= dst_w_reg)
                    && (SWY'(emit_row_reg) + SWY'(1) >= dst_h_reg);

    // position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_col_reg <= '0;
            load_row_reg <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end else begin
            load_col_reg <= load_col_next;
            load_row_reg <= load_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
        end
    end

    // coordinate mappers
    nns_div #(
        .MAX_SIZE (MAX_WIDTH),
        .STEPS    (STEPS)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (emit_beat),
        .pos      (emit_col_reg),
        .src_size (src_w_reg),
        .dst_size (dst_w_reg),
        .done     (div_x_done),
        .quot     (src_x)
    );

    nns_div #(
        .MAX_SIZE (MAX_HEIGHT),
        .STEPS    (STEPS)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (emit_beat),
        .pos      (emit_row_reg),
        .src_size (src_h_reg),
        .dst_size (dst_h_reg),
        .done     (div_y_done),
        .quot     (src_y)
    );

    // frame store addressing
    assign wr_addr  = AW'(load_row_reg) * ROW_STRIDE + AW'(load_col_reg);
    assign wr_pixel = '{red: s_in_red, green: s_in_green, blue: s_in_blue};
    assign rd_en    = (state_reg == ST_DIV) && div_x_done;
    assign rd_addr  = AW'(src_y) * ROW_STRIDE + AW'(src_x);

    nns_fstore #(
        .DEPTH (DEPTH)
    ) u_fstore (
        .aclk    (aclk),
        .wr_en   (load_beat),
        .wr_addr (wr_addr),
        .wr_data (wr_pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_pixel)
    );

    // emit sequencer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (emit_beat) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_x_done) begin
                        state_reg <= ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // a newly placed result takes over from the one being drained
            if (state_reg == ST_DATA && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (emit_beat) begin
            last_reg <= emit_last;
        end
        if (state_reg == ST_DATA && out_free) begin
            m_pix_reg  <= rd_pixel;
            m_last_reg <= last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg.red;
    assign m_out_green = m_pix_reg.green;
    assign m_out_blue  = m_pix_reg.blue;
    assign m_frame_end = m_last_reg;

    // both mappers run in lockstep
    a_div_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        div_x_done == div_y_done)
        else $error("scaler: coordinate mappers out of step");

    // an emit blocks further input until its result is placed
    a_emit_block: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_beat |=> !s_ready)
        else $error("scaler: input taken during an emit");

    // a new result only comes from the data state
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DATA))
        else $error("scaler: output valid without frame store data");

endmodule
